/* sv/mett_pkg.sv */
// shared types, constants and command/status structs for the motion event tracker
`timescale 1ns / 1ps
package mett_pkg;

  localparam int MAX_EVENTS = 64;
  localparam int COORD_BITS = 12;
  localparam int FRAME_BITS = 24;
  localparam int IDX_W      = $clog2(MAX_EVENTS);
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
  localparam int EDGE_W     = COORD_BITS + 1;
  localparam int AREA_W     = 2 * COORD_BITS;
  localparam int INTER_W    = 2 * EDGE_W;
  localparam int I100_W     = INTER_W + 7;
  localparam int SUM_W      = AREA_W + 1;
  localparam int LHS_W      = I100_W + SUM_W;
  localparam int R1_W       = 8 + AREA_W;
  localparam int RHS_W      = R1_W + AREA_W;
  localparam int CMP_W      = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  typedef struct packed {
    logic                  open;
    logic                  seen;
    logic [FRAME_BITS-1:0] start_f;
    logic [FRAME_BITS-1:0] stop_f;
    box_t                  box;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    OP_DETECT = 2'd0,
    OP_EOF    = 2'd1,
    OP_FILTER = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_MATCHED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_CLOSED    = 3'd3,
    ST_KEPT      = 3'd4,
    ST_NONE_KEPT = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef enum logic {
    REG_FPS = 1'b0,
    REG_PCT = 1'b1
  } reg_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_MATCH,
    WR_INSERT,
    WR_EOF,
    WR_KEEP
  } wr_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_ZERO,
    CNT_N
  } cnt_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_MATCH,
    EM_INSERT,
    EM_DROP,
    EM_CLOSED,
    EM_KEPT,
    EM_NONE_KEPT,
    EM_CLEARED
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  rd;
    logic  cap;
    logic  idx_inc;
    logic  idx_clr;
    logic  n_inc;
    wr_t   wr;
    cnt_t  cnt;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic idx_at_count;
    logic idx_at_n;
    logic full;
    logic match;
    logic keep;
    logic close;
    logic ent_open;
    logic n_zero;
  } stat_t;

endpackage

/* sv/mett_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module mett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/mett_ctrl.sv */
// sequencer for detection, end of frame, filter and clear operations
`timescale 1ns / 1ps
module mett_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      opcode,
  input  mett_pkg::stat_t stat,
  output mett_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_D_RD,
    S_D_CAP,
    S_D_CMP,
    S_D_DEC,
    S_E_RD,
    S_E_CAP,
    S_E_WR,
    S_F_RD,
    S_F_CAP,
    S_F_WR,
    S_F_CHK,
    S_R_RD,
    S_R_CAP,
    S_R_EM,
    S_CLR
  } state_t;

  state_t     state, state_next;
  logic [1:0] wcnt, wcnt_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    wcnt_next  = wcnt;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (mett_pkg::op_t'(opcode))
            mett_pkg::OP_DETECT: state_next = S_D_RD;
            mett_pkg::OP_EOF:    state_next = S_E_RD;
            mett_pkg::OP_FILTER: state_next = S_F_RD;
            mett_pkg::OP_CLEAR:  state_next = S_CLR;
          endcase
        end
      end
      S_D_RD: begin
        if (stat.idx_at_count) begin
          if (stat.full) begin
            cmd.emit = mett_pkg::EM_DROP;
          end else begin
            cmd.wr   = mett_pkg::WR_INSERT;
            cmd.cnt  = mett_pkg::CNT_INC;
            cmd.emit = mett_pkg::EM_INSERT;
          end
          state_next = S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_D_CAP;
        end
      end
      S_D_CAP: begin
        cmd.cap    = 1'b1;
        wcnt_next  = '0;
        state_next = S_D_CMP;
      end
      S_D_CMP: begin
        wcnt_next = wcnt + 2'd1;
        if (wcnt == 2'd3) begin
          state_next = S_D_DEC;
        end
      end
      S_D_DEC: begin
        if (stat.ent_open && stat.match) begin
          cmd.wr     = mett_pkg::WR_MATCH;
          cmd.emit   = mett_pkg::EM_MATCH;
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_D_RD;
        end
      end
      S_E_RD: begin
        if (stat.idx_at_count) begin
          cmd.emit   = mett_pkg::EM_CLOSED;
          state_next = S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_E_CAP;
        end
      end
      S_E_CAP: begin
        cmd.cap    = 1'b1;
        state_next = S_E_WR;
      end
      S_E_WR: begin
        cmd.wr      = mett_pkg::WR_EOF;
        cmd.n_inc   = stat.close;
        cmd.idx_inc = 1'b1;
        state_next  = S_E_RD;
      end
      S_F_RD: begin
        if (stat.idx_at_count) begin
          cmd.cnt    = mett_pkg::CNT_N;
          state_next = S_F_CHK;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_F_CAP;
        end
      end
      S_F_CAP: begin
        cmd.cap    = 1'b1;
        state_next = S_F_WR;
      end
      S_F_WR: begin
        if (stat.keep) begin
          cmd.wr    = mett_pkg::WR_KEEP;
          cmd.n_inc = 1'b1;
        end
        cmd.idx_inc = 1'b1;
        state_next  = S_F_RD;
      end
      S_F_CHK: begin
        cmd.idx_clr = 1'b1;
        if (stat.n_zero) begin
          cmd.emit   = mett_pkg::EM_NONE_KEPT;
          state_next = S_IDLE;
        end else begin
          state_next = S_R_RD;
        end
      end
      S_R_RD: begin
        if (stat.idx_at_n) begin
          state_next = S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_R_CAP;
        end
      end
      S_R_CAP: begin
        cmd.cap    = 1'b1;
        state_next = S_R_EM;
      end
      S_R_EM: begin
        cmd.emit    = mett_pkg::EM_KEPT;
        cmd.idx_inc = 1'b1;
        state_next  = S_R_RD;
      end
      S_CLR: begin
        cmd.cnt    = mett_pkg::CNT_ZERO;
        cmd.emit   = mett_pkg::EM_CLEARED;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wcnt  <= '0;
    end else begin
      state <= state_next;
      wcnt  <= wcnt_next;
    end
  end

endmodule

/* sv/mett_dp.sv */
// datapath: item and entry registers, counters, overlap pipeline, result registers
`timescale 1ns / 1ps
module mett_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mett_pkg::cmd_t                       cmd,
  output mett_pkg::stat_t                      stat,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_index,
  input  logic [7:0]                           cfg_data,
  input  logic [mett_pkg::COORD_BITS-1:0]      box_x,
  input  logic [mett_pkg::COORD_BITS-1:0]      box_y,
  input  logic [mett_pkg::COORD_BITS-1:0]      box_w,
  input  logic [mett_pkg::COORD_BITS-1:0]      box_h,
  input  logic [mett_pkg::FRAME_BITS-1:0]      frame_number,
  output logic                                 ram_we,
  output logic [mett_pkg::IDX_W-1:0]           ram_waddr,
  output logic [mett_pkg::ENTRY_W-1:0]         ram_wdata,
  output logic                                 ram_re,
  output logic [mett_pkg::IDX_W-1:0]           ram_raddr,
  input  logic [mett_pkg::ENTRY_W-1:0]         ram_rdata,
  output logic                                 result_strobe,
  output logic [2:0]                           status,
  output logic [mett_pkg::IDX_W-1:0]           slot,
  output logic [mett_pkg::FRAME_BITS-1:0]      start_frame,
  output logic [mett_pkg::FRAME_BITS-1:0]      end_frame,
  output logic [mett_pkg::COORD_BITS-1:0]      out_x,
  output logic [mett_pkg::COORD_BITS-1:0]      out_y,
  output logic [mett_pkg::COORD_BITS-1:0]      out_w,
  output logic [mett_pkg::COORD_BITS-1:0]      out_h,
  output logic [mett_pkg::CNT_W-1:0]           event_total,
  output logic                                 last
);

  localparam int CB = mett_pkg::COORD_BITS;
  localparam int FB = mett_pkg::FRAME_BITS;
  localparam int CW = mett_pkg::CNT_W;

  logic [7:0] fps;
  logic [6:0] pct;

  mett_pkg::box_t         item_box;
  logic [FB-1:0]          item_frame;
  mett_pkg::entry_t       ent;
  logic [CW-1:0]          idx, n, count;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fps <= 8'd25;
      pct <= 7'd65;
    end else if (cfg_valid) begin
      unique case (mett_pkg::reg_t'(cfg_index))
        mett_pkg::REG_FPS: fps <= cfg_data;
        mett_pkg::REG_PCT: pct <= cfg_data[6:0];
      endcase
    end
  end

  // item and entry registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_box   <= '{x: box_x, y: box_y, w: box_w, h: box_h};
      item_frame <= frame_number;
    end
    if (cmd.cap) begin
      ent <= mett_pkg::entry_t'(ram_rdata);
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      n     <= '0;
      count <= '0;
    end else begin
      if (cmd.load || cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.load) begin
        n <= '0;
      end else if (cmd.n_inc) begin
        n <= n + CW'(1);
      end
      unique case (cmd.cnt)
        mett_pkg::CNT_HOLD: count <= count;
        mett_pkg::CNT_INC:  count <= count + CW'(1);
        mett_pkg::CNT_ZERO: count <= '0;
        mett_pkg::CNT_N:    count <= n;
      endcase
    end
  end

  // overlap pipeline, stage 1: edges, touch test, areas
  logic [mett_pkg::EDGE_W-1:0]  ar, ab, br, bb, rmin, lmax, bmin, tmax;
  logic                         s1_touch;
  logic [mett_pkg::EDGE_W-1:0]  s1_dx, s1_dy;
  logic [mett_pkg::AREA_W-1:0]  s1_a1, s1_a2;

  assign ar   = {1'b0, ent.box.x} + {1'b0, ent.box.w};
  assign ab   = {1'b0, ent.box.y} + {1'b0, ent.box.h};
  assign br   = {1'b0, item_box.x} + {1'b0, item_box.w};
  assign bb   = {1'b0, item_box.y} + {1'b0, item_box.h};
  assign rmin = (ar < br) ? ar : br;
  assign bmin = (ab < bb) ? ab : bb;
  assign lmax = (ent.box.x > item_box.x) ? {1'b0, ent.box.x} : {1'b0, item_box.x};
  assign tmax = (ent.box.y > item_box.y) ? {1'b0, ent.box.y} : {1'b0, item_box.y};

  always_ff @(posedge clk) begin
    s1_touch <= !((ar < {1'b0, item_box.x}) || ({1'b0, ent.box.x} > br) ||
                  (ab < {1'b0, item_box.y}) || ({1'b0, ent.box.y} > bb));
    s1_dx    <= rmin - lmax;
    s1_dy    <= bmin - tmax;
    s1_a1    <= mett_pkg::AREA_W'(ent.box.w) * mett_pkg::AREA_W'(ent.box.h);
    s1_a2    <= mett_pkg::AREA_W'(item_box.w) * mett_pkg::AREA_W'(item_box.h);
  end

  // stage 2: intersection, area sum, 2*percent*a1
  logic                          s2_ok;
  logic [mett_pkg::INTER_W-1:0]  s2_inter;
  logic [mett_pkg::SUM_W-1:0]    s2_sum;
  logic [mett_pkg::R1_W-1:0]     s2_r1;
  logic [mett_pkg::AREA_W-1:0]   s2_a2;

  always_ff @(posedge clk) begin
    s2_ok    <= s1_touch && (s1_a1 != '0) && (s1_a2 != '0);
    s2_inter <= mett_pkg::INTER_W'(s1_dx) * mett_pkg::INTER_W'(s1_dy);
    s2_sum   <= mett_pkg::SUM_W'(s1_a1) + mett_pkg::SUM_W'(s1_a2);
    s2_r1    <= mett_pkg::R1_W'({pct, 1'b0}) * mett_pkg::R1_W'(s1_a1);
    s2_a2    <= s1_a2;
  end

  // stage 3: intersection times 100
  logic                          s3_ok;
  logic [mett_pkg::I100_W-1:0]   s3_i100;
  logic [mett_pkg::SUM_W-1:0]    s3_sum;
  logic [mett_pkg::R1_W-1:0]     s3_r1;
  logic [mett_pkg::AREA_W-1:0]   s3_a2;

  always_ff @(posedge clk) begin
    s3_ok   <= s2_ok;
    s3_i100 <= mett_pkg::I100_W'(s2_inter) * mett_pkg::I100_W'(7'd100);
    s3_sum  <= s2_sum;
    s3_r1   <= s2_r1;
    s3_a2   <= s2_a2;
  end

  // stage 4: both cross products
  logic                        s4_ok;
  logic [mett_pkg::LHS_W-1:0]  s4_lhs;
  logic [mett_pkg::RHS_W-1:0]  s4_rhs;

  always_ff @(posedge clk) begin
    s4_ok  <= s3_ok;
    s4_lhs <= mett_pkg::LHS_W'(s3_i100) * mett_pkg::LHS_W'(s3_sum);
    s4_rhs <= mett_pkg::RHS_W'(s3_r1) * mett_pkg::RHS_W'(s3_a2);
  end

  // filter length test
  logic [FB:0] lim;
  assign lim = {1'b0, ent.start_f} + (FB + 1)'({fps, 1'b0});

  always_comb begin
    stat.idx_at_count = (idx == count);
    stat.idx_at_n     = (idx == n);
    stat.full         = (count == CW'(mett_pkg::MAX_EVENTS));
    stat.match        = s4_ok &&
                        (mett_pkg::CMP_W'(s4_lhs) > mett_pkg::CMP_W'(s4_rhs));
    stat.keep         = !ent.open && ({1'b0, ent.stop_f} >= lim);
    stat.close        = !ent.seen && ent.open;
    stat.ent_open     = ent.open;
    stat.n_zero       = (n == '0);
  end

  // table writes
  mett_pkg::entry_t wentry;

  always_comb begin
    wentry    = ent;
    ram_we    = 1'b1;
    ram_waddr = idx[mett_pkg::IDX_W-1:0];
    unique case (cmd.wr)
      mett_pkg::WR_NONE: begin
        ram_we = 1'b0;
      end
      mett_pkg::WR_MATCH: begin
        wentry.seen = 1'b1;
        wentry.box  = item_box;
      end
      mett_pkg::WR_INSERT: begin
        wentry    = '{open: 1'b1, seen: 1'b1, start_f: item_frame, stop_f: '0,
                      box: item_box};
        ram_waddr = count[mett_pkg::IDX_W-1:0];
      end
      mett_pkg::WR_EOF: begin
        wentry.open = ent.open && ent.seen;
        wentry.seen = 1'b0;
        if (stat.close) begin
          wentry.stop_f = item_frame;
        end
      end
      mett_pkg::WR_KEEP: begin
        ram_waddr = n[mett_pkg::IDX_W-1:0];
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_wdata = wentry;
  assign ram_re    = cmd.rd;
  assign ram_raddr = idx[mett_pkg::IDX_W-1:0];

  // result formation
  mett_pkg::status_t              r_status;
  logic [mett_pkg::IDX_W-1:0]     r_slot;
  logic [FB-1:0]                  r_start, r_stop;
  mett_pkg::box_t                 r_box;
  logic [CW-1:0]                  r_total;
  logic                           r_last;

  always_comb begin
    r_status = mett_pkg::ST_CLEARED;
    r_slot   = '0;
    r_start  = '0;
    r_stop   = '0;
    r_box    = '0;
    r_total  = '0;
    r_last   = 1'b1;
    unique case (cmd.emit)
      mett_pkg::EM_NONE: begin
        r_last = 1'b0;
      end
      mett_pkg::EM_MATCH: begin
        r_status = mett_pkg::ST_MATCHED;
        r_slot   = idx[mett_pkg::IDX_W-1:0];
        r_start  = ent.start_f;
        r_box    = item_box;
      end
      mett_pkg::EM_INSERT: begin
        r_status = mett_pkg::ST_INSERTED;
        r_slot   = count[mett_pkg::IDX_W-1:0];
        r_start  = item_frame;
        r_box    = item_box;
      end
      mett_pkg::EM_DROP:      r_status = mett_pkg::ST_DROPPED;
      mett_pkg::EM_CLOSED: begin
        r_status = mett_pkg::ST_CLOSED;
        r_total  = n;
      end
      mett_pkg::EM_KEPT: begin
        r_status = mett_pkg::ST_KEPT;
        r_slot   = idx[mett_pkg::IDX_W-1:0];
        r_start  = ent.start_f;
        r_stop   = ent.stop_f;
        r_box    = ent.box;
        r_total  = n;
        r_last   = (idx + CW'(1) == n);
      end
      mett_pkg::EM_NONE_KEPT: r_status = mett_pkg::ST_NONE_KEPT;
      mett_pkg::EM_CLEARED:   r_status = mett_pkg::ST_CLEARED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cmd.emit != mett_pkg::EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != mett_pkg::EM_NONE) begin
      status      <= r_status;
      slot        <= r_slot;
      start_frame <= r_start;
      end_frame   <= r_stop;
      out_x       <= r_box.x;
      out_y       <= r_box.y;
      out_w       <= r_box.w;
      out_h       <= r_box.h;
      event_total <= r_total;
      last        <= r_last;
    end
  end

endmodule

/* sv/motion_event_tracker_table_core.sv */
// top level of the motion event tracker table
`timescale 1ns / 1ps
// Motion event tracker: an item is taken when start is high and busy is low;
// each result appears for exactly one cycle with result_strobe high and must
// be captured then, as there is no way to hold it off. Timing is set by the
// sequential walk over the event table memory (one read per entry). A
// detection visits the table entries in turn (read, capture and the four-stage
// cross-multiply overlap pipeline), ending early on the first match. End of
// frame reads, captures and rewrites each stored event; filter writes the kept
// events to the front of the table, then reads each back and issues a result
// for it; clear empties the table. busy stays high until the final result
// (last high) has been issued. Configuration beats are always taken
// (cfg_ready is tied high) and must only be sent while idle.
module motion_event_tracker_table_core (
  input  logic                             clk,
  input  logic                             rst,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       opcode,
  input  logic [mett_pkg::COORD_BITS-1:0]  box_x,
  input  logic [mett_pkg::COORD_BITS-1:0]  box_y,
  input  logic [mett_pkg::COORD_BITS-1:0]  box_w,
  input  logic [mett_pkg::COORD_BITS-1:0]  box_h,
  input  logic [mett_pkg::FRAME_BITS-1:0]  frame_number,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [7:0]                       cfg_data,
  // result side
  output logic                             result_strobe,
  output logic [2:0]                       status,
  output logic [mett_pkg::IDX_W-1:0]       slot,
  output logic [mett_pkg::FRAME_BITS-1:0]  start_frame,
  output logic [mett_pkg::FRAME_BITS-1:0]  end_frame,
  output logic [mett_pkg::COORD_BITS-1:0]  out_x,
  output logic [mett_pkg::COORD_BITS-1:0]  out_y,
  output logic [mett_pkg::COORD_BITS-1:0]  out_w,
  output logic [mett_pkg::COORD_BITS-1:0]  out_h,
  output logic [mett_pkg::CNT_W-1:0]       event_total,
  output logic                             last
);

  mett_pkg::cmd_t  cmd;
  mett_pkg::stat_t stat;

  // table memory ports
  logic                          ram_we, ram_re;
  logic [mett_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [mett_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

  // config beats never stall
  assign cfg_ready = 1'b1;

  mett_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  mett_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .box_x         (box_x),
    .box_y         (box_y),
    .box_w         (box_w),
    .box_h         (box_h),
    .frame_number  (frame_number),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .result_strobe (result_strobe),
    .status        (status),
    .slot          (slot),
    .start_frame   (start_frame),
    .end_frame     (end_frame),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_w         (out_w),
    .out_h         (out_h),
    .event_total   (event_total),
    .last          (last)
  );

  // one row per event: open, seen, start, end, box
  mett_ram #(
    .WIDTH (mett_pkg::ENTRY_W),
    .DEPTH (mett_pkg::MAX_EVENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* sv/mett_checker.sv */
// port-level checks for the motion event tracker, bound to the top level
`timescale 1ns / 1ps
module mett_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            result_strobe,
  input logic [2:0]                      status,
  input logic [mett_pkg::IDX_W-1:0]      slot,
  input logic                            last
);

  // an accepted item always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // results only appear while busy or right after a busy period
  a_no_idle_result: assert property (@(posedge clk) disable iff (rst)
    (!busy && $past(!busy)) |-> !result_strobe)
    else $error("result beat while idle");

  // the final beat of an item is never followed directly by another
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last) |=> !result_strobe)
    else $error("result beat right after last");

  // dropped, closed, none-kept and cleared results always close the item and carry no slot
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (status == 3'(mett_pkg::ST_DROPPED) ||
                       status == 3'(mett_pkg::ST_CLOSED) ||
                       status == 3'(mett_pkg::ST_NONE_KEPT) ||
                       status == 3'(mett_pkg::ST_CLEARED)))
    |-> (last && slot == '0))
    else $error("single-result status without last or with a slot");

endmodule

bind motion_event_tracker_table_core mett_checker u_mett_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .status        (status),
  .slot          (slot),
  .last          (last)
);
